// ===== hdl/mate_pair_classifier_defines.svh =====
// Assertion macros shared by the mate pair classifier RTL.
`ifndef MATE_PAIR_CLASSIFIER_DEFINES_SVH
`define MATE_PAIR_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS
`define MPC_ASSERT_IMM(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mate pair classifier check failed");
`define MPC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mate pair classifier check failed");
`else
`define MPC_ASSERT_IMM(label, ante, cons)
`define MPC_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== hdl/mpc_pkg.sv =====
// Types and constants of the mate pair classifier.
package mpc_pkg;

    localparam int unsigned POS_W      = 32;
    localparam int unsigned LEN_W      = 16;
    localparam int unsigned LIB_W      = 20;
    localparam int unsigned MULT_W     = 8;
    localparam int unsigned GAP_W      = 16;
    localparam int unsigned CNT_W      = 8;
    localparam int unsigned END_W      = 34;
    localparam int unsigned SPAN_W     = 36;
    localparam int unsigned CMP_W      = 40;
    localparam int unsigned PROD_W     = 28;

    localparam int unsigned S_TDATA_W  = 144;
    localparam int unsigned S_TUSER_W  = 1;
    localparam int unsigned M_TDATA_W  = 136;
    localparam int unsigned M_TUSER_W  = 3;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DEV_MULT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REAS_SD   = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_SD  = 8'd3;

    localparam logic [MULT_W-1:0] RST_DEV_MULT  = 8'd32;
    localparam logic [GAP_W-1:0]  RST_GAP_LIMIT = 16'd100;
    localparam logic [CNT_W-1:0]  RST_REAS_SD   = 8'd10;
    localparam logic [CNT_W-1:0]  RST_CLOSE_SD  = 8'd8;

    typedef enum logic [2:0] {
        ST_HAPPY      = 3'd0,
        ST_STRETCHED  = 3'd1,
        ST_COMPRESSED = 3'd2,
        ST_ORIENT     = 3'd3,
        ST_LINKING    = 3'd4,
        ST_SINGLETON  = 3'd5,
        ST_UNMATED    = 3'd6
    } t_status;

    typedef struct packed {
        logic [POS_W-1:0] a_off;
        logic [LEN_W-1:0] a_len;
        logic             a_rev;
        logic             b_here;
        logic [POS_W-1:0] b_off;
        logic [LEN_W-1:0] b_len;
        logic             b_rev;
        logic             mate_known;
        logic             mate_contig;
        logic             transposon;
        logic [LIB_W-1:0] mean;
        logic [LIB_W-1:0] sd;
    } t_pair_in;

    typedef struct packed {
        logic [POS_W-1:0]  a_beg;
        logic [POS_W-1:0]  b_beg;
        logic [END_W-1:0]  a_end;
        logic [END_W-1:0]  b_end;
        logic [LEN_W-1:0]  a_len;
        logic              a_rev;
        logic              b_rev;
        logic              b_here;
        logic              mate_known;
        logic              mate_contig;
        logic              transposon;
        logic [LIB_W-1:0]  mean;
        logic [PROD_W-1:0] dev_sd;
        logic [PROD_W-1:0] reas_sd;
        logic [PROD_W-1:0] close_sd;
    } t_stage2;

endpackage

// ===== hdl/mate_pair_classifier.sv =====
// Mate pair classifier: status, span and connectivity flags of one read pair.
// Throughput is one pair per cycle while the output is not stalled: input register,
// a stage that forms read ends and the deviation products, and a result register,
// each refilled when it empties.
// Synchronous active-low reset empties all stages and loads the register defaults.
// Configuration writes are taken in every cycle with no wait.
`include "mate_pair_classifier_defines.svh"

module mate_pair_classifier (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // first_offset, first_length, first_reverse, second_present, second_offset,
    // second_length, second_reverse, mate_known, mate_contig_known,
    // library_mean, library_sd, zero fill
    input  logic [mpc_pkg::S_TDATA_W-1:0]    i_s_axis_tdata,
    // transposon_pair
    input  logic [mpc_pkg::S_TUSER_W-1:0]    i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // left_end, right_end, span_length, actual_distance, reasonably_linked,
    // closely_linked, zero fill
    output logic [mpc_pkg::M_TDATA_W-1:0]    o_m_axis_tdata,
    // status
    output logic [mpc_pkg::M_TUSER_W-1:0]    o_m_axis_tuser,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mpc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mpc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    logic [mpc_pkg::MULT_W-1:0] r_dev_mult;
    logic [mpc_pkg::GAP_W-1:0]  r_gap_limit;
    logic [mpc_pkg::CNT_W-1:0]  r_reas_sd;
    logic [mpc_pkg::CNT_W-1:0]  r_close_sd;

    logic              r_s1_valid;
    mpc_pkg::t_pair_in r_s1;
    logic              r_s2_valid;
    mpc_pkg::t_stage2  r_s2;
    mpc_pkg::t_stage2  n_s2;
    logic              r_out_valid;

    mpc_pkg::t_status          r_out_status;
    logic [mpc_pkg::POS_W-1:0] r_out_left;
    logic [mpc_pkg::POS_W-1:0] r_out_right;
    logic [mpc_pkg::POS_W-1:0] r_out_span;
    logic [mpc_pkg::POS_W-1:0] r_out_actual;
    logic                      r_out_reas;
    logic                      r_out_close;

    mpc_pkg::t_status          n_status;
    logic [mpc_pkg::POS_W-1:0] n_left;
    logic [mpc_pkg::POS_W-1:0] n_right;
    logic [mpc_pkg::POS_W-1:0] n_span;
    logic [mpc_pkg::POS_W-1:0] n_actual;
    logic                      n_reas;
    logic                      n_close;

    logic s_accept;
    logic s1_adv;
    logic s2_adv;
    logic s3_adv;

    assign s3_adv          = !r_out_valid || i_m_axis_tready;
    assign s2_adv          = !r_s2_valid || s3_adv;
    assign s1_adv          = !r_s1_valid || s2_adv;
    assign o_s_axis_tready = s1_adv;
    assign s_accept        = i_s_axis_tvalid && s1_adv;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_mult  <= mpc_pkg::RST_DEV_MULT;
            r_gap_limit <= mpc_pkg::RST_GAP_LIMIT;
            r_reas_sd   <= mpc_pkg::RST_REAS_SD;
            r_close_sd  <= mpc_pkg::RST_CLOSE_SD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                mpc_pkg::CFG_DEV_MULT:  r_dev_mult  <= i_cfg_data[mpc_pkg::MULT_W-1:0];
                mpc_pkg::CFG_GAP_LIMIT: r_gap_limit <= i_cfg_data[mpc_pkg::GAP_W-1:0];
                mpc_pkg::CFG_REAS_SD:   r_reas_sd   <= i_cfg_data[mpc_pkg::CNT_W-1:0];
                mpc_pkg::CFG_CLOSE_SD:  r_close_sd  <= i_cfg_data[mpc_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= i_s_axis_tvalid;
        end
        if (s_accept) begin
            r_s1.a_off       <= i_s_axis_tdata[31:0];
            r_s1.a_len       <= i_s_axis_tdata[47:32];
            r_s1.a_rev       <= i_s_axis_tdata[48];
            r_s1.b_here      <= i_s_axis_tdata[49];
            r_s1.b_off       <= i_s_axis_tdata[81:50];
            r_s1.b_len       <= i_s_axis_tdata[97:82];
            r_s1.b_rev       <= i_s_axis_tdata[98];
            r_s1.mate_known  <= i_s_axis_tdata[99];
            r_s1.mate_contig <= i_s_axis_tdata[100];
            r_s1.mean        <= i_s_axis_tdata[120:101];
            r_s1.sd          <= i_s_axis_tdata[140:121];
            r_s1.transposon  <= i_s_axis_tuser[0];
        end
    end

    always_comb begin
        n_s2.a_beg       = r_s1.a_off;
        n_s2.b_beg       = r_s1.b_off;
        n_s2.a_end       = {{2{r_s1.a_off[31]}}, r_s1.a_off} + {18'd0, r_s1.a_len} - 34'd1;
        n_s2.b_end       = {{2{r_s1.b_off[31]}}, r_s1.b_off} + {18'd0, r_s1.b_len} - 34'd1;
        n_s2.a_len       = r_s1.a_len;
        n_s2.a_rev       = r_s1.a_rev;
        n_s2.b_rev       = r_s1.b_rev;
        n_s2.b_here      = r_s1.b_here;
        n_s2.mate_known  = r_s1.mate_known;
        n_s2.mate_contig = r_s1.mate_contig;
        n_s2.transposon  = r_s1.transposon;
        n_s2.mean        = r_s1.mean;
        n_s2.dev_sd      = {20'd0, r_dev_mult} * {8'd0, r_s1.sd};
        n_s2.reas_sd     = {20'd0, r_reas_sd} * {8'd0, r_s1.sd};
        n_s2.close_sd    = {20'd0, r_close_sd} * {8'd0, r_s1.sd};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_adv) begin
            r_s2_valid <= r_s1_valid;
        end
        if (s2_adv) begin
            r_s2 <= n_s2;
        end
    end

    logic signed [mpc_pkg::SPAN_W-1:0] a_beg_x;
    logic signed [mpc_pkg::SPAN_W-1:0] b_beg_x;
    logic signed [mpc_pkg::SPAN_W-1:0] a_end_x;
    logic signed [mpc_pkg::SPAN_W-1:0] b_end_x;
    logic signed [mpc_pkg::SPAN_W-1:0] left_x;
    logic signed [mpc_pkg::SPAN_W-1:0] right_x;
    logic signed [mpc_pkg::SPAN_W-1:0] span_x;
    logic signed [mpc_pkg::SPAN_W-1:0] gap_x;
    logic signed [mpc_pkg::SPAN_W-1:0] mean_x;
    logic signed [mpc_pkg::SPAN_W-1:0] reas_x;
    logic signed [mpc_pkg::SPAN_W-1:0] close_x;
    logic signed [mpc_pkg::SPAN_W-1:0] limit_x;
    logic signed [mpc_pkg::SPAN_W-1:0] dev_x;
    logic signed [mpc_pkg::SPAN_W-1:0] dev_abs;
    logic signed [mpc_pkg::CMP_W-1:0]  span16;
    logic signed [mpc_pkg::CMP_W-1:0]  mean16;
    logic signed [mpc_pkg::CMP_W-1:0]  devsd16;
    logic                              orient_bad;
    logic                              sized;

    always_comb begin
        a_beg_x = {{4{r_s2.a_beg[31]}}, r_s2.a_beg};
        b_beg_x = {{4{r_s2.b_beg[31]}}, r_s2.b_beg};
        a_end_x = {{2{r_s2.a_end[33]}}, r_s2.a_end};
        b_end_x = {{2{r_s2.b_end[33]}}, r_s2.b_end};
        mean_x  = {16'd0, r_s2.mean};
        reas_x  = {8'd0, r_s2.reas_sd};
        close_x = {8'd0, r_s2.close_sd};
        limit_x = {20'd0, r_gap_limit};
        mean16  = {16'd0, r_s2.mean, 4'd0};
        devsd16 = {12'd0, r_s2.dev_sd};

        left_x  = (a_beg_x < b_beg_x) ? a_beg_x : b_beg_x;
        right_x = (a_end_x > b_end_x) ? a_end_x : b_end_x;
        span_x  = right_x - left_x + 36'sd1;
        gap_x   = r_s2.a_rev ? (b_beg_x - a_end_x) : (a_beg_x - b_end_x);
        span16  = {span_x, 4'd0};
        dev_x   = span_x - mean_x;
        dev_abs = dev_x[mpc_pkg::SPAN_W-1] ? -dev_x : dev_x;

        if (r_s2.transposon) begin
            orient_bad = (r_s2.a_rev == r_s2.b_rev) ||
                         (r_s2.a_rev && (a_end_x > b_end_x || b_beg_x < a_beg_x)) ||
                         (r_s2.b_rev && (b_end_x > a_end_x || a_beg_x < b_beg_x));
        end else begin
            orient_bad = (r_s2.a_rev == r_s2.b_rev) ||
                         (r_s2.a_rev && (a_beg_x < b_beg_x || b_end_x > a_end_x)) ||
                         (r_s2.b_rev && (b_beg_x < a_beg_x || a_end_x > b_end_x));
        end

        n_status = mpc_pkg::ST_HAPPY;
        n_reas   = 1'b0;
        n_close  = 1'b0;
        sized    = 1'b0;
        if (r_s2.b_here) begin
            n_left  = left_x[mpc_pkg::POS_W-1:0];
            n_right = right_x[mpc_pkg::POS_W-1:0];
            n_span  = span_x[mpc_pkg::POS_W-1:0];
            if (r_s2.transposon) begin
                n_actual = gap_x[mpc_pkg::POS_W-1:0];
                if (gap_x > limit_x) begin
                    n_status = mpc_pkg::ST_STRETCHED;
                end
                if (orient_bad) begin
                    n_status = mpc_pkg::ST_ORIENT;
                end
                n_reas = 1'b1;
            end else begin
                n_actual = span_x[mpc_pkg::POS_W-1:0];
                if (span16 > mean16 + devsd16) begin
                    n_status = mpc_pkg::ST_STRETCHED;
                end else if (span16 + devsd16 < mean16) begin
                    n_status = mpc_pkg::ST_COMPRESSED;
                end
                if (orient_bad) begin
                    n_status = mpc_pkg::ST_ORIENT;
                end
                sized   = (n_status != mpc_pkg::ST_ORIENT);
                n_reas  = (n_status == mpc_pkg::ST_HAPPY) ||
                          (n_status == mpc_pkg::ST_COMPRESSED) ||
                          ((n_status == mpc_pkg::ST_STRETCHED) && (span_x <= mean_x + reas_x));
                n_close = sized && (dev_abs < close_x);
            end
        end else begin
            n_left   = r_s2.a_beg;
            n_right  = r_s2.a_end[mpc_pkg::POS_W-1:0];
            n_actual = {16'd0, r_s2.a_len};
            n_span   = {12'd0, r_s2.mean};
            if (!r_s2.mate_known) begin
                n_status = mpc_pkg::ST_UNMATED;
                n_span   = {16'd0, r_s2.a_len};
            end else if (!r_s2.mate_contig) begin
                n_status = mpc_pkg::ST_SINGLETON;
            end else begin
                n_status = mpc_pkg::ST_LINKING;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s3_adv) begin
            r_out_valid <= r_s2_valid;
        end
        if (s3_adv) begin
            r_out_status <= n_status;
            r_out_left   <= n_left;
            r_out_right  <= n_right;
            r_out_span   <= n_span;
            r_out_actual <= n_actual;
            r_out_reas   <= n_reas;
            r_out_close  <= n_close;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_close, r_out_reas, r_out_actual, r_out_span,
                              r_out_right, r_out_left};
    assign o_m_axis_tuser  = r_out_status;

    `MPC_ASSERT_IMM(a_unplaced_no_flags, r_out_valid && (r_out_status == mpc_pkg::ST_LINKING || r_out_status == mpc_pkg::ST_SINGLETON || r_out_status == mpc_pkg::ST_UNMATED), !r_out_reas && !r_out_close)
    `MPC_ASSERT_IMM(a_orient_not_close, r_out_valid && r_out_status == mpc_pkg::ST_ORIENT, !r_out_close)
    `MPC_ASSERT_NXT(a_s1_held, r_s1_valid && !s2_adv, r_s1_valid && $stable(r_s1))
    `MPC_ASSERT_NXT(a_s2_held, r_s2_valid && !s3_adv, r_s2_valid && $stable(r_s2))

endmodule
